// ===== rtl/otr_pkg.sv =====
// Package: types and constants shared by the one-shot timer modules.
`default_nettype none
package otr_pkg;

	typedef enum logic [1:0] {
		OP_EVAL        = 2'd0,
		OP_TRIGGER     = 2'd1,
		OP_SET_DISABLE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		CFG_DURATION = 2'd0,
		CFG_RETRIG   = 2'd1,
		CFG_HOLD     = 2'd2
	} cfg_idx_t;

	typedef enum logic {
		ST_IDLE,
		ST_DIV
	} state_t;

	localparam int unsigned DIV_STEPS = 16;
	localparam int unsigned CNT_BITS  = 4;
	localparam logic [16:0] RAMP_ONE  = 17'h10000;
	localparam logic [31:0] DUR_RESET = 32'd1000;

	typedef struct packed {
		logic accept;
		logic step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic need_div;
		logic res_valid;
	} sts_t;

endpackage
`default_nettype wire

// ===== rtl/otr_ctrl.sv =====
// Controller: item handshake and sequencing of the ramp divide.
`default_nettype none
module otr_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          item_valid,
	output logic               item_stall,
	input  wire logic          result_stall,
	input  wire otr_pkg::sts_t sts,
	output otr_pkg::cmd_t      cmd
);
	import otr_pkg::*;

	state_t               state_q, state_nxt;
	logic [CNT_BITS-1:0]  cnt_q;
	logic                 res_free;
	logic                 last_step;

	assign res_free  = !sts.res_valid || !result_stall;
	assign last_step = (cnt_q == CNT_BITS'(DIV_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_comb begin
		state_nxt  = state_q;
		item_stall = 1'b1;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				item_stall = !res_free;
				cmd.accept = item_valid && res_free;
				if (cmd.accept && sts.need_div) begin
					state_nxt = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (last_step) begin
					cmd.finish = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/otr_dp.sv =====
// Datapath: timer state, configuration registers, restoring divider, result register.
`default_nettype none
module otr_dp #(
	parameter int unsigned TIME_BITS = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_write,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [31:0]   cfg_data,
	input  wire logic [1:0]    operation,
	input  wire logic [31:0]   now_time,
	input  wire logic          disable_level,
	input  wire otr_pkg::cmd_t cmd,
	output otr_pkg::sts_t      sts,
	input  wire logic          result_stall,
	output logic               outputs_valid,
	output logic               active,
	output logic [31:0]        elapsed_out,
	output logic [16:0]        ramp_fraction,
	output logic               outputs_enabled
);
	import otr_pkg::*;

	localparam int unsigned CW = (TIME_BITS > 32) ? TIME_BITS : 32;

	logic [31:0]          dur_q;
	logic                 retrig_q;
	logic                 hold_q;
	logic                 running_q;
	logic [TIME_BITS-1:0] start_q;
	logic [31:0]          held_q;
	logic                 disabled_q;

	logic [31:0]          rem_q;
	logic [31:0]          div_q;
	logic [15:0]          quot_q;

	logic                 res_valid_q;
	logic                 ov_q;
	logic                 act_q;
	logic [31:0]          el_q;
	logic [16:0]          ramp_q;
	logic                 en_q;

	logic [TIME_BITS-1:0] now_t;
	logic [TIME_BITS-1:0] elapsed;
	logic                 in_run;
	logic                 nxt_running;
	logic                 nxt_disabled;
	logic                 ld_start;
	logic                 ld_held;
	logic                 r_ov;
	logic                 r_act;
	logic [31:0]          r_el;
	logic [16:0]          r_ramp;
	logic                 r_en;
	logic                 need_div;
	logic [32:0]          rem_dbl;
	logic [32:0]          rem_sub;
	logic                 q_bit;
	logic [15:0]          quot_nxt;

	assign now_t   = TIME_BITS'(now_time);
	assign elapsed = now_t - start_q;
	assign in_run  = CW'(elapsed) < CW'(dur_q);

	always_comb begin
		nxt_running  = running_q;
		nxt_disabled = disabled_q;
		ld_start     = 1'b0;
		ld_held      = 1'b0;
		r_ov         = 1'b0;
		r_act        = 1'b0;
		r_el         = '0;
		r_ramp       = '0;
		r_en         = !disabled_q;
		need_div     = 1'b0;
		case (op_t'(operation))
			OP_EVAL: begin
				if (!disabled_q) begin
					r_ov  = 1'b1;
					r_act = running_q;
					if (running_q) begin
						if (in_run) begin
							r_el     = 32'(elapsed);
							need_div = 1'b1;
						end else begin
							r_el        = dur_q;
							r_ramp      = RAMP_ONE;
							ld_held     = hold_q;
							nxt_running = 1'b0;
						end
					end else if (hold_q) begin
						r_el   = held_q;
						r_ramp = RAMP_ONE;
					end
				end
			end
			OP_TRIGGER: begin
				if ((!running_q || retrig_q) && !disabled_q) begin
					ld_start    = 1'b1;
					nxt_running = 1'b1;
					r_ov        = 1'b1;
				end
			end
			OP_SET_DISABLE: begin
				nxt_disabled = disable_level;
				if (disable_level) begin
					nxt_running = 1'b0;
				end
				r_en = !disable_level;
			end
			default: begin
			end
		endcase
	end

	// one quotient bit per step; remainder stays below the divisor
	assign rem_dbl  = {rem_q, 1'b0};
	assign rem_sub  = rem_dbl - {1'b0, div_q};
	assign q_bit    = !rem_sub[32];
	assign quot_nxt = {quot_q[14:0], q_bit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dur_q       <= DUR_RESET;
			retrig_q    <= 1'b0;
			hold_q      <= 1'b0;
			running_q   <= 1'b0;
			start_q     <= '0;
			held_q      <= '0;
			disabled_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_idx_t'(cfg_index))
					CFG_DURATION: dur_q    <= cfg_data;
					CFG_RETRIG:   retrig_q <= cfg_data[0];
					CFG_HOLD:     hold_q   <= cfg_data[0];
					default: begin
					end
				endcase
			end
			if (cmd.accept) begin
				running_q  <= nxt_running;
				disabled_q <= nxt_disabled;
				if (ld_start) begin
					start_q <= now_t;
				end
				if (ld_held) begin
					held_q <= dur_q;
				end
			end
			if ((cmd.accept && !need_div) || cmd.finish) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ov_q   <= r_ov;
			act_q  <= r_act;
			el_q   <= r_el;
			ramp_q <= r_ramp;
			en_q   <= r_en;
			rem_q  <= 32'(elapsed);
			div_q  <= dur_q;
			quot_q <= '0;
		end else if (cmd.step) begin
			rem_q  <= q_bit ? rem_sub[31:0] : rem_dbl[31:0];
			quot_q <= quot_nxt;
			if (cmd.finish) begin
				ramp_q <= {1'b0, quot_nxt};
			end
		end
	end

	assign sts.need_div  = need_div;
	assign sts.res_valid = res_valid_q;

	assign outputs_valid   = ov_q;
	assign active          = act_q;
	assign elapsed_out     = el_q;
	assign ramp_fraction   = ramp_q;
	assign outputs_enabled = en_q;

endmodule
`default_nettype wire

// ===== rtl/oneshot_timer_with_ramp_core.sv =====
// Top level of the retriggerable one-shot timer with progress ramp.
// Usage:
//   Items enter on item_valid/item_stall with operation, now_time and
//   disable_level; each item gives exactly one result on result_valid/
//   result_stall. Registers are written through cfg_write/cfg_index/cfg_data
//   while the block is idle, a rule for the user that the block does not
//   enforce: 0 duration, 1 retriggerable, 2 hold final. An item that needs
//   no ramp divide is written to the result register on acceptance. For an
//   evaluate inside a running run the ramp is produced by a restoring divider
//   that resolves one quotient bit per cycle for a 16-bit quotient. One item
//   is worked on at a time: short operations are taken at one item per cycle
//   while the result is not stalled, and none during a mid-run evaluate.
//   The next item is taken as soon as the result register is empty or is
//   being read in the same cycle; a stalled result holds its fields and
//   holds off further items.
//   Reset clears the timer state, the disable flag and the held duration,
//   and sets duration to 1000 with both mode bits clear.
`default_nettype none
module oneshot_timer_with_ramp_core #(
	parameter int unsigned TIME_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic [1:0]  operation,
	input  wire logic [31:0] now_time,
	input  wire logic        disable_level,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic             outputs_valid,
	output logic             active,
	output logic [31:0]      elapsed_out,
	output logic [16:0]      ramp_fraction,
	output logic             outputs_enabled
);
	import otr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	otr_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_stall (result_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	otr_dp #(
		.TIME_BITS (TIME_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.operation       (operation),
		.now_time        (now_time),
		.disable_level   (disable_level),
		.cmd             (cmd),
		.sts             (sts),
		.result_stall    (result_stall),
		.outputs_valid   (outputs_valid),
		.active          (active),
		.elapsed_out     (elapsed_out),
		.ramp_fraction   (ramp_fraction),
		.outputs_enabled (outputs_enabled)
	);

	assign result_valid = sts.res_valid;

endmodule
`default_nettype wire

// ===== rtl/otr_chk.sv =====
// Port-level checker for the one-shot timer, bound to the top level.
`default_nettype none
module otr_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        item_valid,
	input wire logic        item_stall,
	input wire logic        result_valid,
	input wire logic        result_stall,
	input wire logic        outputs_valid,
	input wire logic        active,
	input wire logic [31:0] elapsed_out,
	input wire logic [16:0] ramp_fraction,
	input wire logic        outputs_enabled
);

	// a waiting result is not dropped
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	// masked outputs never carry an update
	a_mask: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !outputs_enabled |-> !outputs_valid)
		else $error("update reported while disabled");

	// an active report always comes from a valid evaluate
	a_active: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && active |-> outputs_valid && outputs_enabled)
		else $error("active without valid update");

	// ramp never exceeds one
	a_ramp: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ramp_fraction <= 17'h10000)
		else $error("ramp above one");

	// no item taken while a stalled result is still waiting
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |-> item_stall || !item_valid)
		else $error("item taken over a waiting result");

endmodule

bind oneshot_timer_with_ramp_core otr_chk u_otr_chk (.*);
`default_nettype wire
